// ----- src/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define MRR_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MRR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define MRR_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/mrr_pkg.sv -----
// ----------------------------------------------------------------------------
// mrr_pkg
// Types, constants and the crc step for the read-registers response receiver.
// ----------------------------------------------------------------------------
package mrr_pkg;

  localparam int BUF_DEPTH          = 64;
  localparam int BUF_AW             = $clog2(BUF_DEPTH);
  localparam int MAX_BYTE_COUNT_DEF = 64;
  localparam int QUEUE_DEPTH        = 2;
  localparam int WORDS_W            = 6;
  localparam int POS_W              = 7;

  localparam logic [7:0]  FUNC_READ_REGS = 8'h03;
  localparam logic [7:0]  ADDR_RESET     = 8'd247;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [POS_W-1:0] HDR_LEN   = POS_W'(3);

  typedef enum logic [2:0] {
    ST_CONT  = 3'd0,
    ST_OK    = 3'd1,
    ST_CRC   = 3'd2,
    ST_FRAME = 3'd3,
    ST_START = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_CRC     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_HI   = 2'd1,
    BK_LO   = 2'd2
  } back_state_t;

  // one queued job: a plain status result, or a word burst when nwords is nonzero
  typedef struct packed {
    status_t            status;
    logic [WORDS_W-1:0] nwords;
  } q_entry_t;

  typedef struct packed {
    logic done;
    logic active;
  } back_stat_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] x;
    x = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
    end
    return x;
  endfunction

endpackage

// ----- src/mrr_channels.sv -----
// ----------------------------------------------------------------------------
// mrr channels
// Valid/ready channel bundles for input bytes, results and configuration.
// ----------------------------------------------------------------------------
interface mrr_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink (input valid, input cmd, input rx_byte, output ready);
endinterface

interface mrr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        word_valid;
  logic [4:0]  reg_index;
  logic [15:0] reg_word;
  logic        last;

  modport source (output valid, output status, output word_valid, output reg_index,
                  output reg_word, output last, input ready);
  modport sink (input valid, input status, input word_valid, input reg_index,
                input reg_word, input last, output ready);
endinterface

interface mrr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/mrr_ram.sv -----
// ----------------------------------------------------------------------------
// mrr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/mrr_queue.sv -----
// ----------------------------------------------------------------------------
// mrr_queue
// Short job queue between the byte front end and the result back end.
// ----------------------------------------------------------------------------
module mrr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mrr_pkg::q_entry_t push_data,
  input  logic              pop,
  output mrr_pkg::q_entry_t head,
  output logic              empty,
  output logic              full
);

  localparam int PW = (mrr_pkg::QUEUE_DEPTH > 1) ? $clog2(mrr_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(mrr_pkg::QUEUE_DEPTH + 1);

  mrr_pkg::q_entry_t slots [mrr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == CW'(mrr_pkg::QUEUE_DEPTH));
  assign head  = slots[rd_ptr_r];

  // pointer wrap relies on a power-of-two depth
  always_comb begin
    wr_ptr_nxt = push ? PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = CW'(cnt_r + 1'b1);
    end else if (pop && !push) begin
      cnt_nxt = CW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/mrr_front.sv -----
// ----------------------------------------------------------------------------
// mrr_front
// Frame parser: checks header, buffers payload, runs the crc, queues jobs.
// ----------------------------------------------------------------------------
module mrr_front #(
  parameter int MAX_BYTE_COUNT = mrr_pkg::MAX_BYTE_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_cmd,
  input  logic [7:0]                 in_byte,
  output logic                       in_ready,
  input  logic [7:0]                 exp_addr,
  output logic                       push,
  output mrr_pkg::q_entry_t          push_data,
  input  logic                       q_full,
  input  mrr_pkg::back_stat_t        bstat,
  output logic                       busy,
  output logic                       ram_we,
  output logic [mrr_pkg::BUF_AW-1:0] ram_waddr,
  output logic [7:0]                 ram_wdata
);

  // byte count is legal when below this bound
  localparam int LIM_A = MAX_BYTE_COUNT - 5;
  localparam int LIM_B = (LIM_A < mrr_pkg::BUF_DEPTH + 1) ? LIM_A : mrr_pkg::BUF_DEPTH + 1;
  localparam int COUNT_LIMIT = (LIM_B > 0) ? LIM_B : 0;

  localparam int PW = mrr_pkg::POS_W;

  mrr_pkg::phase_t phase_r, phase_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [PW-1:0]   count_r, count_nxt;
  logic [15:0]     crc_r, crc_nxt;
  logic [7:0]      crc_lo_r, crc_lo_nxt;
  logic            busy_r, busy_nxt;

  logic            accept;
  logic [15:0]     crc_step;
  logic [PW:0]     pos_inc_ext;
  logic [PW:0]     end_pos_ext;
  logic [PW-1:0]   pos_inc;
  logic [PW-1:0]   pay_off;

  assign in_ready    = !q_full && !busy_r;
  assign accept      = in_valid && in_ready;
  assign busy        = busy_r;
  assign crc_step    = mrr_pkg::crc_feed(crc_r, in_byte);
  assign pos_inc     = PW'(pos_r + 1'b1);
  assign pos_inc_ext = {1'b0, pos_r} + (PW+1)'(1);
  assign end_pos_ext = {1'b0, count_r} + (PW+1)'(3);
  assign pay_off     = PW'(pos_r - mrr_pkg::HDR_LEN);
  assign ram_waddr   = pay_off[mrr_pkg::BUF_AW-1:0];
  assign ram_wdata   = in_byte;

  always_comb begin
    phase_nxt        = phase_r;
    pos_nxt          = pos_r;
    count_nxt        = count_r;
    crc_nxt          = crc_r;
    crc_lo_nxt       = crc_lo_r;
    busy_nxt         = busy_r && !bstat.done;
    push             = accept;
    push_data.status = mrr_pkg::ST_CONT;
    push_data.nwords = '0;
    ram_we           = 1'b0;

    if (accept) begin
      if (in_cmd) begin
        phase_nxt        = mrr_pkg::PH_HEADER;
        pos_nxt          = '0;
        count_nxt        = '0;
        crc_nxt          = mrr_pkg::CRC_INIT;
        crc_lo_nxt       = '0;
        push_data.status = mrr_pkg::ST_START;
      end else begin
        unique case (phase_r)
          mrr_pkg::PH_HEADER: begin
            logic hdr_ok;
            hdr_ok = 1'b0;
            if (pos_r == PW'(0)) begin
              hdr_ok = (in_byte == exp_addr);
            end else if (pos_r == PW'(1)) begin
              hdr_ok = (in_byte == mrr_pkg::FUNC_READ_REGS);
            end else begin
              hdr_ok = ({1'b0, in_byte} < 9'(COUNT_LIMIT));
              if (hdr_ok) begin
                count_nxt = in_byte[PW-1:0];
                phase_nxt = (in_byte == 8'd0) ? mrr_pkg::PH_CRC : mrr_pkg::PH_PAYLOAD;
              end
            end
            if (hdr_ok) begin
              crc_nxt = crc_step;
              pos_nxt = pos_inc;
            end else begin
              phase_nxt        = mrr_pkg::PH_IDLE;
              push_data.status = mrr_pkg::ST_FRAME;
            end
          end
          mrr_pkg::PH_PAYLOAD: begin
            ram_we  = 1'b1;
            crc_nxt = crc_step;
            pos_nxt = pos_inc;
            if (pos_inc_ext >= end_pos_ext) begin
              phase_nxt = mrr_pkg::PH_CRC;
            end
          end
          mrr_pkg::PH_CRC: begin
            pos_nxt = pos_inc;
            if ({1'b0, pos_r} == end_pos_ext) begin
              crc_lo_nxt = in_byte;
            end else begin
              phase_nxt = mrr_pkg::PH_IDLE;
              if ({in_byte, crc_lo_r} != crc_r) begin
                push_data.status = mrr_pkg::ST_CRC;
              end else begin
                // crc good: report frame ok, with the word burst for the back end if any
                push_data.status = mrr_pkg::ST_OK;
                push_data.nwords = count_r[PW-1:1];
                busy_nxt         = (count_r[PW-1:1] != '0);
              end
            end
          end
          default: begin
            push_data.status = mrr_pkg::ST_FRAME;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= mrr_pkg::PH_IDLE;
      pos_r    <= '0;
      count_r  <= '0;
      crc_r    <= mrr_pkg::CRC_INIT;
      crc_lo_r <= '0;
      busy_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      count_r  <= count_nxt;
      crc_r    <= crc_nxt;
      crc_lo_r <= crc_lo_nxt;
      busy_r   <= busy_nxt;
    end
  end

endmodule

// ----- src/mrr_back.sv -----
// ----------------------------------------------------------------------------
// mrr_back
// Result sequencer: emits queued status results and reads out word bursts.
// ----------------------------------------------------------------------------
module mrr_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mrr_pkg::q_entry_t          head,
  input  logic                       q_empty,
  output logic                       pop,
  output logic                       ram_re,
  output logic [mrr_pkg::BUF_AW-1:0] ram_raddr,
  input  logic [7:0]                 ram_rdata,
  output mrr_pkg::back_stat_t        bstat,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic                       out_word_valid,
  output logic [4:0]                 out_reg_index,
  output logic [15:0]                out_reg_word,
  output logic                       out_last
);

  localparam int WW = mrr_pkg::WORDS_W;

  mrr_pkg::back_state_t state_r, state_nxt;
  logic [WW-1:0] words_r, words_nxt;
  logic [4:0]    k_r, k_nxt;
  logic [7:0]    hi_r, hi_nxt;

  logic          valid_r, valid_nxt;
  logic [2:0]    status_r, status_nxt;
  logic          wv_r, wv_nxt;
  logic [4:0]    idx_r, idx_nxt;
  logic [15:0]   word_r, word_nxt;
  logic          last_r, last_nxt;

  logic          out_free;
  logic          last_word;

  assign out_free  = !valid_r || out_ready;
  assign last_word = ({1'b0, k_r} + WW'(1)) == words_r;

  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_word_valid = wv_r;
  assign out_reg_index  = idx_r;
  assign out_reg_word   = word_r;
  assign out_last       = last_r;

  always_comb begin
    state_nxt    = state_r;
    words_nxt    = words_r;
    k_nxt        = k_r;
    hi_nxt       = hi_r;
    valid_nxt    = valid_r && !out_ready;
    status_nxt   = status_r;
    wv_nxt       = wv_r;
    idx_nxt      = idx_r;
    word_nxt     = word_r;
    last_nxt     = last_r;
    pop          = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    bstat.done   = 1'b0;
    bstat.active = (state_r != mrr_pkg::BK_IDLE);

    unique case (state_r)
      mrr_pkg::BK_IDLE: begin
        if (!q_empty && out_free) begin
          pop = 1'b1;
          if (head.nwords == '0) begin
            valid_nxt  = 1'b1;
            status_nxt = head.status;
            wv_nxt     = 1'b0;
            idx_nxt    = '0;
            word_nxt   = '0;
            last_nxt   = 1'b1;
          end else begin
            words_nxt = head.nwords;
            k_nxt     = '0;
            ram_re    = 1'b1;
            state_nxt = mrr_pkg::BK_HI;
          end
        end
      end
      mrr_pkg::BK_HI: begin
        hi_nxt    = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = {k_r, 1'b1};
        state_nxt = mrr_pkg::BK_LO;
      end
      mrr_pkg::BK_LO: begin
        // read data holds while the output register is still occupied
        if (out_free) begin
          valid_nxt  = 1'b1;
          status_nxt = mrr_pkg::ST_OK;
          wv_nxt     = 1'b1;
          idx_nxt    = k_r;
          word_nxt   = {hi_r, ram_rdata};
          last_nxt   = last_word;
          if (last_word) begin
            bstat.done = 1'b1;
            state_nxt  = mrr_pkg::BK_IDLE;
          end else begin
            k_nxt     = k_r + 5'd1;
            ram_re    = 1'b1;
            ram_raddr = {k_r + 5'd1, 1'b0};
            state_nxt = mrr_pkg::BK_HI;
          end
        end
      end
      default: begin
        state_nxt = mrr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mrr_pkg::BK_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    words_r  <= words_nxt;
    k_r      <= k_nxt;
    hi_r     <= hi_nxt;
    status_r <= status_nxt;
    wv_r     <= wv_nxt;
    idx_r    <= idx_nxt;
    word_r   <= word_nxt;
    last_r   <= last_nxt;
  end

endmodule

// ----- src/modbus_read_response_receiver.sv -----
// ----------------------------------------------------------------------------
// modbus_read_response_receiver
// Checks one read-registers response frame byte by byte and emits its words.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one item per serial byte; cmd=1 opens a new frame (status started).
//   out_ch : one result per byte, or on a good frame one result per register
//            word (big-endian, indexed from 0), the final one with last set.
//   cfg_ch : writes the expected slave address, always ready; write it only
//            while no item is in flight.
// Path: a status result goes through the job queue to the result register;
//   each word of a good frame is read from the buffer in BK_HI, then BK_LO.
// Throughput: one byte per cycle while the result side keeps up; after the
//   final crc byte of a good frame the input stalls for the word burst, which
//   reads each word's two bytes in turn from the buffer's single read port.
// Reset: no frame open, address register 247, output channel empty. The
//   payload buffer is not cleared; only bytes of the current frame are read.
// Output stall: the result register holds; the job queue fills and then
//   in_ch.ready drops until results are taken again.
module modbus_read_response_receiver #(
  parameter int MAX_BYTE_COUNT = mrr_pkg::MAX_BYTE_COUNT_DEF
) (
  input logic         clk,
  input logic         rst_n,
  mrr_in_if.sink      in_ch,
  mrr_out_if.source   out_ch,
  mrr_cfg_if.sink     cfg_ch
);

  `include "assert_macros.svh"

  logic [7:0]                 addr_r;
  logic                       push;
  logic                       pop;
  logic                       q_empty;
  logic                       q_full;
  logic                       busy;
  mrr_pkg::q_entry_t          push_data;
  mrr_pkg::q_entry_t          head;
  mrr_pkg::back_stat_t        bstat;
  logic                       ram_we;
  logic [mrr_pkg::BUF_AW-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic                       ram_re;
  logic [mrr_pkg::BUF_AW-1:0] ram_raddr;
  logic [7:0]                 ram_rdata;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= mrr_pkg::ADDR_RESET;
    end else if (cfg_ch.valid) begin
      addr_r <= cfg_ch.data;
    end
  end

  mrr_front #(
    .MAX_BYTE_COUNT(MAX_BYTE_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_cmd    (in_ch.cmd),
    .in_byte   (in_ch.rx_byte),
    .in_ready  (in_ch.ready),
    .exp_addr  (addr_r),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full),
    .bstat     (bstat),
    .busy      (busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  mrr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  mrr_ram #(
    .WIDTH(8),
    .DEPTH(mrr_pkg::BUF_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mrr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (pop),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .bstat          (bstat),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_word_valid (out_ch.word_valid),
    .out_reg_index  (out_ch.reg_index),
    .out_reg_word   (out_ch.reg_word),
    .out_last       (out_ch.last)
  );

  // a word burst runs only while the front end holds off new bytes
  `MRR_ASSERT_IMPLY(a_burst_blocks_input, clk, rst_n, bstat.active, busy && !in_ch.ready,
                    "word burst active while input is open")
  // never queue into a full queue
  `MRR_ASSERT_IMPLY(a_no_push_full, clk, rst_n, push, !q_full || pop,
                    "job pushed into full queue")
  // word results always report frame ok
  `MRR_ASSERT_IMPLY(a_word_status, clk, rst_n, out_ch.valid && out_ch.word_valid,
                    out_ch.status == 3'(mrr_pkg::ST_OK), "word result without frame ok")
  // reset empties the result channel
  `MRR_ASSERT_ALWAYS_NEXT(a_reset_out, clk, !rst_n, !out_ch.valid,
                          "result valid after reset")

endmodule

// ----- tb/sv/modbus_read_response_receiver_tb.sv -----
// ----------------------------------------------------------------------------
// modbus_read_response_receiver_tb
// Drives read-registers response frames byte by byte, some good, some cut
// short, with bad headers, bad crc or stray bytes, under random idling on both
// channels. Every result is checked field by field against a frame decoder
// kept in the scoreboard, for several slave addresses.
// ----------------------------------------------------------------------------
module modbus_read_response_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mrr_pkg::*;

  localparam int N_ITEMS      = 480;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_LIMIT = 10;
  localparam int MAX_GOOD     = MAX_BYTE_COUNT_DEF - 6;
  localparam int WHOLE        = 1000;

  typedef struct packed {
    status_t     status;
    logic        word_valid;
    logic [4:0]  reg_index;
    logic [15:0] reg_word;
    logic        last;
  } reg_result_t;

  class frame_scoreboard;
    logic [7:0]  slave_addr;
    logic [7:0]  pos;
    logic [7:0]  count;
    logic [7:0]  crc_lo;
    logic [15:0] crc;
    phase_t      phase;
    logic [7:0]  payload [BUF_DEPTH];
    reg_result_t response_q [$];
    int unsigned errors;

    function new();
      slave_addr = ADDR_RESET;
      pos        = '0;
      count      = '0;
      crc_lo     = '0;
      crc        = CRC_INIT;
      phase      = PH_IDLE;
      errors     = 0;
    endfunction

    function void set_address(logic [7:0] a);
      slave_addr = a;
    endfunction

    // reflected crc-16, one data bit per step, lsb first
    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ b[i];
        r  = r >> 1;
        if (fb) r = r ^ CRC_POLY;
      end
      return r;
    endfunction

    function void expect_result(status_t st, logic wv, logic [4:0] idx, logic [15:0] w,
                                logic lst);
      reg_result_t r;
      r.status     = st;
      r.word_valid = wv;
      r.reg_index  = idx;
      r.reg_word   = w;
      r.last       = lst;
      response_q.push_back(r);
    endfunction

    function void note_rx_item(logic cmd, logic [7:0] b);
      logic [5:0]  slot;
      logic [15:0] rx_crc;
      int          words;
      bit          hdr_ok;
      if (cmd) begin
        pos    = '0;
        count  = '0;
        crc    = CRC_INIT;
        crc_lo = '0;
        phase  = PH_HEADER;
        expect_result(ST_START, 1'b0, '0, '0, 1'b1);
        return;
      end
      case (phase)
        PH_HEADER: begin
          hdr_ok = 1'b1;
          if (pos == 8'd0) begin
            hdr_ok = (b == slave_addr);
          end else if (pos == 8'd1) begin
            hdr_ok = (b == FUNC_READ_REGS);
          end else begin
            hdr_ok = (int'(b) < MAX_BYTE_COUNT_DEF - 5) && (int'(b) <= BUF_DEPTH);
            if (hdr_ok) begin
              count = b;
              phase = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
            end
          end
          if (hdr_ok) begin
            crc = crc_step(crc, b);
            pos = pos + 8'd1;
            expect_result(ST_CONT, 1'b0, '0, '0, 1'b1);
          end else begin
            phase = PH_IDLE;
            expect_result(ST_FRAME, 1'b0, '0, '0, 1'b1);
          end
        end
        PH_PAYLOAD: begin
          slot          = 6'(pos - 8'd3);
          payload[slot] = b;
          crc           = crc_step(crc, b);
          pos           = pos + 8'd1;
          if (int'(pos) >= int'(count) + 3) phase = PH_CRC;
          expect_result(ST_CONT, 1'b0, '0, '0, 1'b1);
        end
        PH_CRC: begin
          if (int'(pos) == int'(count) + 3) begin
            crc_lo = b;
            pos    = pos + 8'd1;
            expect_result(ST_CONT, 1'b0, '0, '0, 1'b1);
          end else begin
            rx_crc = {b, crc_lo};
            words  = int'(count) >> 1;
            phase  = PH_IDLE;
            pos    = pos + 8'd1;
            if (rx_crc != crc) begin
              expect_result(ST_CRC, 1'b0, '0, '0, 1'b1);
            end else if (words == 0) begin
              expect_result(ST_OK, 1'b0, '0, '0, 1'b1);
            end else begin
              for (int k = 0; k < words; k++) begin
                expect_result(ST_OK, 1'b1, 5'(k), {payload[2*k], payload[2*k+1]},
                              k == words - 1);
              end
            end
          end
        end
        default: begin
          // no frame open
          expect_result(ST_FRAME, 1'b0, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function string show(reg_result_t r);
      return $sformatf("status %0d word_valid %0b index %0d word %h last %0b",
                       r.status, r.word_valid, r.reg_index, r.reg_word, r.last);
    endfunction

    function void check_result(reg_result_t got);
      reg_result_t want;
      if (response_q.size() == 0) begin
        if (errors < REPORT_LIMIT) $display("result with nothing awaited: %s", show(got));
        errors++;
        return;
      end
      want = response_q.pop_front();
      if (got !== want) begin
        if (errors < REPORT_LIMIT) begin
          $display("result mismatch at %0t", $realtime);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
        errors++;
      end
    endfunction

    function int pending();
      return response_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  mrr_in_if  in_ch ();
  mrr_out_if out_ch ();
  mrr_cfg_if cfg_ch ();

  modbus_read_response_receiver i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_scoreboard sb;
  bit              gaps_on;
  int              hold_requests;
  int              items_sent;
  int              cycle_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // accepted items and results, both taken at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_ch.valid && in_ch.ready) sb.note_rx_item(in_ch.cmd, in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result({out_ch.status, out_ch.word_valid, out_ch.reg_index,
                         out_ch.reg_word, out_ch.last});
      end
    end
  end

  // result side: random stalls, plus a long hold-off when asked for
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !(gaps_on && $urandom_range(99) < 26);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_item(input logic cmd, input logic [7:0] b);
    while (gaps_on && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // start item, then the first keep bytes of the frame
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                            input logic [7:0] count, input bit bad_crc,
                            input bit extreme_fill, input int keep);
    logic [7:0]  frame_bytes [$];
    logic [15:0] crc;
    frame_bytes.push_back(addr);
    frame_bytes.push_back(func);
    frame_bytes.push_back(count);
    if (int'(count) <= MAX_GOOD) begin
      for (int i = 0; i < int'(count); i++) begin
        if (extreme_fill) frame_bytes.push_back(i[0] ? 8'hFF : 8'h00);
        else frame_bytes.push_back(8'($urandom_range(255)));
      end
    end
    crc = CRC_INIT;
    foreach (frame_bytes[i]) crc = sb.crc_step(crc, frame_bytes[i]);
    if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(15));
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    send_item(1'b1, 8'($urandom_range(255)));
    for (int i = 0; i < keep && i < frame_bytes.size(); i++) send_item(1'b0, frame_bytes[i]);
  endtask

  task automatic run_phase(input int upto);
    int         sel;
    int         cnt;
    logic [7:0] func;
    while (items_sent < upto) begin
      sel = $urandom_range(99);
      cnt = ($urandom_range(9) == 0) ? $urandom_range(MAX_GOOD) : $urandom_range(8);
      if (sel < 70) begin
        send_frame(sb.slave_addr, FUNC_READ_REGS, 8'(cnt), $urandom_range(6) == 0, 1'b0,
                   WHOLE);
      end else if (sel < 78) begin
        // cut short, the next start reopens
        send_frame(sb.slave_addr, FUNC_READ_REGS, 8'(cnt), 1'b0, 1'b0,
                   $urandom_range(1, cnt + 4));
      end else if (sel < 83) begin
        send_frame(sb.slave_addr ^ 8'($urandom_range(1, 255)), FUNC_READ_REGS, 8'(cnt),
                   1'b0, 1'b0, 1);
      end else if (sel < 88) begin
        func = 8'($urandom_range(255));
        if (func == FUNC_READ_REGS) func = func ^ 8'h01;
        send_frame(sb.slave_addr, func, 8'(cnt), 1'b0, 1'b0, 2);
      end else if (sel < 93) begin
        send_frame(sb.slave_addr, FUNC_READ_REGS, 8'($urandom_range(MAX_GOOD + 1, 255)),
                   1'b0, 1'b0, 3);
      end else begin
        repeat ($urandom_range(1, 4)) send_item(1'b0, 8'($urandom_range(255)));
      end
    end
  endtask

  // only once every awaited result is in
  task automatic set_slave_address(input logic [7:0] a);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= a;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    sb.set_address(a);
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    cfg_ch.valid  <= 1'b0;
    cfg_ch.data   <= 8'h00;
    rst_n         <= 1'b0;
    gaps_on       = 1'b1;
    hold_requests = 0;
    items_sent    = 0;
    sb            = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes with no frame open, then two good frames and one of each header fault
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_frame(ADDR_RESET, FUNC_READ_REGS, 8'd4, 1'b0, 1'b1, WHOLE);
    send_frame(ADDR_RESET, FUNC_READ_REGS, 8'd0, 1'b0, 1'b0, WHOLE);
    send_frame(8'h11, FUNC_READ_REGS, 8'd2, 1'b0, 1'b0, 1);
    send_frame(ADDR_RESET, 8'h04, 8'd2, 1'b0, 1'b0, 2);
    send_frame(ADDR_RESET, FUNC_READ_REGS, 8'(MAX_GOOD + 1), 1'b0, 1'b0, 3);

    run_phase(140);

    set_slave_address(8'h00);
    // long result stall while the largest frame keeps coming
    hold_requests++;
    send_frame(8'h00, FUNC_READ_REGS, 8'(MAX_GOOD), 1'b0, 1'b0, WHOLE);
    run_phase(260);

    set_slave_address(8'hFF);
    gaps_on = 1'b0;
    run_phase(370);
    gaps_on = 1'b1;

    set_slave_address(8'($urandom_range(1, 254)));
    run_phase(N_ITEMS);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- modbus_read_response_receiver.f -----
+incdir+src
src/mrr_pkg.sv
src/mrr_channels.sv
src/mrr_ram.sv
src/mrr_queue.sv
src/mrr_front.sv
src/mrr_back.sv
src/modbus_read_response_receiver.sv
tb/sv/modbus_read_response_receiver_tb.sv
